[sv/qfr_pkg.sv]
package qfr_pkg;
  localparam int ExpW = 15;
  localparam int ManW = 113;
  localparam logic [ExpW-1:0] ExpMax = 15'h7FFF;
  localparam logic [63:0] QnanHigh = 64'h7FFF800000000000;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
    logic norm;
  } qfr_cmd_t;

  typedef struct packed {
    logic special;
    logic gap_done;
    logic norm_done;
  } qfr_stat_t;
endpackage

[sv/qfr_ctrl.sv]
module qfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_go,
  output logic             in_ready,
  input  qfr_pkg::qfr_stat_t stat,
  output qfr_pkg::qfr_cmd_t  cmd,
  output logic             out_valid,
  input  logic             out_ready
);
  import qfr_pkg::*;

  localparam logic [2:0] Idle = 3'd0;
  localparam logic [2:0] Load = 3'd1;
  localparam logic [2:0] Step = 3'd2;
  localparam logic [2:0] Fix  = 3'd3;
  localparam logic [2:0] Norm = 3'd4;
  localparam logic [2:0] Done = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= Idle;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      Idle: if (in_go) state_next = Load;
      Load: begin
        cmd.load = 1'b1;
        state_next = Step;
      end
      Step: begin
        if (stat.special) state_next = Done;
        else begin
          cmd.step = 1'b1;
          if (stat.gap_done) state_next = Fix;
        end
      end
      Fix: begin
        cmd.fix = 1'b1;
        state_next = Norm;
      end
      Norm: begin
        if (stat.special || stat.norm_done) state_next = Done;
        else cmd.norm = 1'b1;
      end
      Done: if (out_ready) state_next = Idle;
      default: state_next = Idle;
    endcase
  end

  assign in_ready  = (state == Idle);
  assign out_valid = (state == Done);
endmodule

[sv/qfr_dp.sv]
module qfr_dp (
  input  logic               clk,
  input  logic               in_go,
  input  logic [255:0]       in_data,
  input  qfr_pkg::qfr_cmd_t  cmd,
  output qfr_pkg::qfr_stat_t stat,
  output logic [127:0]       rem,
  output logic               invalid
);
  import qfr_pkg::*;

  logic [63:0] xh, xl, yh, yl;
  logic [ManW:0] r, big;
  logic [ExpW:0] e, k;
  logic q, special, inv, neg, sx;
  logic [127:0] res;

  logic [ExpW-1:0] fx, fy;
  logic x_zero, y_zero, x_nan, y_nan;
  logic [ExpW:0] ex, ey;
  logic [ManW:0] mx, my, sub, twice, rneg;
  logic ge;

  assign fx = xh[62:48];
  assign fy = yh[62:48];
  assign x_zero = ({xh[47:0], xl} == '0) && fx == '0;
  assign y_zero = ({yh[47:0], yl} == '0) && fy == '0;
  assign x_nan = fx == ExpMax && {xh[47:0], xl} != '0;
  assign y_nan = fy == ExpMax && {yh[47:0], yl} != '0;
  assign ex = (fx != '0) ? {1'b0, fx} : 16'd1;
  assign ey = (fy != '0) ? {1'b0, fy} : 16'd1;
  assign mx = {1'b0, fx != '0, xh[47:0], xl};
  assign my = {1'b0, fy != '0, yh[47:0], yl};
  assign ge = r >= big;
  assign sub = r - big;
  assign twice = {r[ManW-1:0], 1'b0};
  assign rneg = big - r;

  always_ff @(posedge clk) begin
    if (in_go) {yl, yh, xl, xh} <= in_data;
    if (cmd.load) begin
      sx <= xh[63];
      q <= 1'b0;
      neg <= 1'b0;
      inv <= 1'b0;
      special <= 1'b0;
      r <= mx;
      if (x_nan || y_nan || fx == ExpMax || y_zero) begin
        special <= 1'b1;
        inv <= 1'b1;
        res <= {QnanHigh, 64'd0};
      end else if (fy == ExpMax || x_zero || ex + 16'd1 < ey) begin
        special <= 1'b1;
        res <= {xh, xl};
      end else if (ex < ey) begin
        big <= {my[ManW-1:0], 1'b0};
        e <= ex;
        k <= '0;
      end else begin
        big <= my;
        e <= ey;
        k <= ex - ey;
      end
    end
    if (cmd.step) begin
      if (k != '0) begin
        r <= ge ? {sub[ManW-1:0], 1'b0} : twice;
        k <= k - 16'd1;
      end else if (ge && big != {my[ManW-1:0], 1'b0} | (ex >= ey)) begin
        if (ex >= ey) begin
          r <= sub;
          q <= 1'b1;
        end
      end
    end
    if (cmd.fix) begin
      if (twice >= big && (twice != big || q)) begin
        r <= rneg;
        neg <= 1'b1;
      end
    end else if (stat.norm_done == 1'b0 && cmd.norm) begin
      r <= twice;
      e <= e - 16'd1;
    end
  end

  logic zero_r;
  assign zero_r = r == '0;
  assign stat.special = special;
  assign stat.gap_done = k == '0;
  assign stat.norm_done = zero_r || r[112] || e <= 16'd1;

  always_comb begin
    if (special) rem = res;
    else if (zero_r) rem = {sx, 127'd0};
    else rem = {sx ^ neg, r[112] ? e[ExpW-1:0] : {ExpW{1'b0}}, r[111:0]};
  end
  assign invalid = special & inv;
endmodule

[sv/quad_float_remainder.sv]
// IEEE 754 binary128 remainder (round-to-nearest-even quotient), exact.
// One item at a time: a new item is accepted only once the last result
// has been taken. After load, one restoring shift-subtract per bit of
// the exponent gap ex - ey (none when ex < ey), a last gap step with the
// final subtract, the final correction, and up to 112 normalizing left
// shifts until the normalize-done check holds; then the result is shown.
// Special operands and an x whose exponent is two or more below that of
// y skip all steps after load and go to the result. A stalled result
// is held in the result state until taken. tdata in: x_high, x_low,
// y_high, y_low; out: rem_high, rem_low in tdata, invalid in tuser.
module quad_float_remainder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,  // x_high, x_low, y_high, y_low
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // rem_high, rem_low
  output logic         m_tuser   // invalid
);
  import qfr_pkg::*;

  qfr_cmd_t  cmd;
  qfr_stat_t stat;
  logic go;
  logic [127:0] rem;

  assign go = s_tvalid & s_tready;

  qfr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(go), .in_ready(s_tready),
    .stat(stat), .cmd(cmd), .out_valid(m_tvalid), .out_ready(m_tready)
  );

  qfr_dp u_dp (
    .clk(clk), .in_go(go), .in_data(s_tdata), .cmd(cmd), .stat(stat),
    .rem(rem), .invalid(m_tuser)
  );

  assign m_tdata = {rem[63:0], rem[127:64]};
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import qfr_pkg::*;

  typedef struct {
    logic [63:0] rem_high;
    logic [63:0] rem_low;
    logic        invalid;
  } rem_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tuser;

  rem_t expected_rems[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  quad_float_remainder u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [127:0] shl1(logic [127:0] a);
    return {a[126:0], 1'b0};
  endfunction

  function automatic rem_t predict_rem(logic [63:0] xh, xl, yh, yl);
    rem_t        res;
    logic [14:0] fx, fy;
    logic [127:0] mx, my, r, big, twice;
    logic        x_zero, y_zero, x_nan, y_nan, q, neg, sign;
    int          ex, ey, e, k;
    logic [14:0] field;
    fx = xh[62:48];
    fy = yh[62:48];
    x_zero = ({xh[47:0], xl} == 0) && fx == 0;
    y_zero = ({yh[47:0], yl} == 0) && fy == 0;
    x_nan = fx == ExpMax && {xh[47:0], xl} != 0;
    y_nan = fy == ExpMax && {yh[47:0], yl} != 0;
    q = 0;
    neg = 0;
    res.rem_high = xh;
    res.rem_low = xl;
    res.invalid = 1'b0;
    if (x_nan || y_nan || fx == ExpMax || y_zero) begin
      res.rem_high = QnanHigh;
      res.rem_low = '0;
      res.invalid = 1'b1;
      return res;
    end
    if (fy == ExpMax || x_zero) return res;
    mx = {16'd0, xh[47:0], xl};
    my = {16'd0, yh[47:0], yl};
    if (fx != 0) mx[112] = 1'b1;
    if (fy != 0) my[112] = 1'b1;
    ex = (fx != 0) ? int'(fx) : 1;
    ey = (fy != 0) ? int'(fy) : 1;
    if (ex < ey - 1) return res;
    r = mx;
    if (ex < ey) begin
      big = shl1(my);
      e = ex;
    end else begin
      big = my;
      for (k = ex - ey; k > 0; k--) begin
        if (r >= big) r = r - big;
        r = shl1(r);
      end
      if (r >= big) begin
        r = r - big;
        q = 1;
      end
      e = ey;
    end
    twice = shl1(r);
    if (twice >= big && (twice != big || q)) begin
      r = big - r;
      neg = 1;
    end
    if (r == 0) begin
      res.rem_high = {xh[63], 63'd0};
      res.rem_low = '0;
      return res;
    end
    sign = xh[63] ^ neg;
    while (r[127:112] == 0 && e > 1) begin
      r = shl1(r);
      e--;
    end
    field = r[112] ? 15'(e) : 15'd0;
    res.rem_high = {sign, field, r[111:64]};
    res.rem_low = r[63:0];
    return res;
  endfunction

  // Receiver: random stall, compare against oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_rems.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          errors++;
        end else begin
          rem_t x;
          x = expected_rems.pop_front();
          if (m_tdata[63:0] !== x.rem_high) begin
            $error("rem_high exp %h got %h", x.rem_high, m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[127:64] !== x.rem_low) begin
            $error("rem_low exp %h got %h", x.rem_low, m_tdata[127:64]);
            errors++;
          end
          if (m_tuser !== x.invalid) begin
            $error("invalid exp %b got %b", x.invalid, m_tuser);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_operands(logic [63:0] xh, xl, yh, yl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {yl, yh, xl, xh};
    expected_rems.push_back(predict_rem(xh, xl, yh, yl));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] mk_high(logic s, logic [14:0] e);
    logic [63:0] v;
    v = rnd64();
    return {s, e, v[47:0]};
  endfunction

  task automatic test_special_operands();
    logic [63:0] one, inf, qnan, snan;
    one = 64'h3FFF000000000000;
    inf = 64'h7FFF000000000000;
    qnan = 64'h7FFF800000000000;
    snan = 64'h7FFF000000000000;
    send_operands(qnan, 0, one, 0);
    send_operands(one, 0, snan, 1);
    send_operands(inf, 0, one, 0);
    send_operands({1'b1, inf[62:0]}, 0, inf, 0);
    send_operands(one, 0, 0, 0);
    send_operands(one, 5, 64'h8000000000000000, 0);
    send_operands(one, 7, inf, 0);
    send_operands(64'h8000000000000000, 0, one, 0);
    send_operands(0, 0, one, 0);
    send_operands(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, one, 0);
  endtask

  task automatic test_directed_arith();
    send_operands(64'h4000800000000000, 0, 64'h4000000000000000, 0); // 3 rem 2 tie
    send_operands(64'h4001400000000000, 0, 64'h4000000000000000, 0); // 5 rem 2 tie
    send_operands(64'h3FFF000000000000, 0, 64'h4001000000000000, 0); // tiny x
    send_operands(64'h3FFF000000000000, 0, 64'h4000000000000000, 0); // gap of one
    send_operands(64'h7FFEFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 0, 1); // max gap
    send_operands(64'h0000FFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 0, 3); // subnormals
    send_operands(64'h0001000000000000, 0, 64'h0000800000000000, 0);
    send_operands(64'hC00C000000000001, 64'h8000000000000000,
                  64'h3FFF800000000000, 1);
    send_operands(64'h4070123456789ABC, rnd64(), 64'hBF8F000000000000, 0);
  endtask

  task automatic test_random(int n);
    logic [63:0] xh, yh;
    logic [14:0] ey;
    int gap;
    repeat (n) begin
      case ($urandom_range(9))
        0: begin
          xh = rnd64();
          yh = rnd64();
        end
        1: begin
          xh = mk_high(1'($urandom), $urandom_range(1) ? 15'h7FFF : 15'h0);
          yh = mk_high(1'($urandom), $urandom_range(1) ? 15'h7FFF : 15'h0);
        end
        default: begin
          ey = 15'($urandom_range(32766));
          gap = $urandom_range(9) == 0 ? $urandom_range(4000) - 200
                                       : $urandom_range(130) - 3;
          if (int'(ey) + gap < 0 || int'(ey) + gap > 32766) gap = 0;
          yh = mk_high(1'($urandom), ey);
          xh = mk_high(1'($urandom), 15'(int'(ey) + gap));
        end
      endcase
      send_operands(xh, rnd64(), yh, $urandom_range(3) == 0 ? 64'd0 : rnd64());
    end
  endtask

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 69;
    test_special_operands();
    test_directed_arith();
    test_random(430);
    send_idle_pct = 69;
    recv_idle_pct = 8;
    test_random(430);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(430);
    s_tvalid <= 1'b0;
    i = 0;
    while (expected_rems.size() != 0 && i < 100000) begin
      @(posedge clk);
      i++;
    end
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_rems.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
